FILE: rtl/csa_pkg.sv
package csa_pkg;

	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;

	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_DIV = 3'd3,
		KIND_REM = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OVER    = 2'd1,
		ST_UNDER   = 2'd2,
		ST_DIVZERO = 2'd3
	} status_t;

	// data that rides alongside the divider stages
	typedef struct packed {
		kind_t               kind;
		logic [DATA_W-1:0]   value;
		status_t             status;
		logic                qneg;
		logic                rneg;
	} side_t;

endpackage

FILE: rtl/csa_div.sv
module csa_div #(
	parameter int W = csa_pkg::DATA_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [W-1:0]         dividend,
	input  logic [W-1:0]         divisor,
	input  csa_pkg::side_t       side_in,
	output logic                 out_valid,
	output logic [W-1:0]         quotient,
	output logic [W-1:0]         remainder,
	output csa_pkg::side_t       side_out
);

	logic                 valid_s [W];
	logic [W-1:0]         rem_s   [W];
	logic [W-1:0]         quo_s   [W];
	logic [W-1:0]         dvs_s   [W];
	csa_pkg::side_t       side_s  [W];

	// one quotient bit per stage, restoring
	for (genvar i = 0; i < W; i++) begin : g_stage
		logic           prev_valid;
		logic [W-1:0]   prev_rem;
		logic [W-1:0]   prev_quo;
		logic [W-1:0]   prev_dvs;
		csa_pkg::side_t prev_side;
		logic [W:0]     trial;
		logic [W:0]     diff;
		logic           fits;

		if (i == 0) begin : g_first
			assign prev_valid = in_valid;
			assign prev_rem   = '0;
			assign prev_quo   = dividend;
			assign prev_dvs   = divisor;
			assign prev_side  = side_in;
		end else begin : g_next
			assign prev_valid = valid_s[i-1];
			assign prev_rem   = rem_s[i-1];
			assign prev_quo   = quo_s[i-1];
			assign prev_dvs   = dvs_s[i-1];
			assign prev_side  = side_s[i-1];
		end

		assign trial = {prev_rem, prev_quo[W-1]};
		assign diff  = trial - {1'b0, prev_dvs};
		assign fits  = ~diff[W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= fits ? diff[W-1:0] : trial[W-1:0];
				quo_s[i]  <= {prev_quo[W-2:0], fits};
				dvs_s[i]  <= prev_dvs;
				side_s[i] <= prev_side;
			end
		end
	end

	assign out_valid = valid_s[W-1];
	assign quotient  = quo_s[W-1];
	assign remainder = rem_s[W-1];
	assign side_out  = side_s[W-1];

endmodule

FILE: rtl/checked_signed_alu_core.sv
// checked signed alu: add, subtract, multiply, divide and remainder on two
// 32-bit two's complement operands, with overflow, underflow and divide by
// zero reported in status; value is 0 whenever status is not ok.
// input channel: in_valid / in_stall carry kind, operand_a, operand_b.
// output channel: out_valid / out_stall carry value and status.
// a beat moves when valid is high and stall is low.
// every operation takes the same path: input register, add/multiply stage,
// 32 divider stages (one quotient bit each) and an output register.
// a new beat can be taken every cycle while in_stall is low; results leave in input order.
// when out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises; nothing is lost or repeated, and it advances again at
// the first clock edge with out_stall low.
// reset clears all valid bits; the pipeline is empty and ready at once.
// kinds 5 to 7 give value 0 with status ok.
module checked_signed_alu_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      kind,
	input  logic signed [csa_pkg::DATA_W-1:0] operand_a,
	input  logic signed [csa_pkg::DATA_W-1:0] operand_b,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [csa_pkg::DATA_W-1:0] value,
	output logic [1:0]                      status
);

	localparam int W = csa_pkg::DATA_W;

	logic en;

	logic                 v_s1;
	logic [2:0]           kind_s1;
	logic signed [W-1:0]  a_s1;
	logic signed [W-1:0]  b_s1;

	logic                 v_s2;
	logic [2:0]           kind_s2;
	logic [W:0]           sum_s2;
	logic signed [csa_pkg::PROD_W-1:0] prod_s2;
	logic [W-1:0]         amag_s2;
	logic [W-1:0]         bmag_s2;
	logic                 qneg_s2;
	logic                 rneg_s2;
	logic                 bzero_s2;

	logic signed [csa_pkg::PROD_W-1:0] prod;
	logic [W:0]           sum;
	csa_pkg::side_t       side_in;

	logic                 dv_valid;
	logic [W-1:0]         dv_quo;
	logic [W-1:0]         dv_rem;
	csa_pkg::side_t       dv_side;

	logic [W-1:0]         fin_value;
	csa_pkg::status_t     fin_status;

	// global advance: hold only when a finished result is not taken
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// input register, and the valid bit of the add/multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			a_s1    <= operand_a;
			b_s1    <= operand_b;
		end
	end

	// add, multiply and operand magnitudes
	assign prod = a_s1 * b_s1;
	assign sum  = (csa_pkg::kind_t'(kind_s1) == csa_pkg::KIND_SUB)
		? ({a_s1[W-1], a_s1} - {b_s1[W-1], b_s1})
		: ({a_s1[W-1], a_s1} + {b_s1[W-1], b_s1});

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2  <= kind_s1;
			sum_s2   <= sum;
			prod_s2  <= prod;
			amag_s2  <= a_s1[W-1] ? (~a_s1 + 1'b1) : a_s1;
			bmag_s2  <= b_s1[W-1] ? (~b_s1 + 1'b1) : b_s1;
			qneg_s2  <= a_s1[W-1] ^ b_s1[W-1];
			rneg_s2  <= a_s1[W-1];
			bzero_s2 <= (b_s1 == '0);
		end
	end

	// range check for add, subtract and multiply; divide by zero check
	always_comb begin
		side_in.kind   = csa_pkg::kind_t'(kind_s2);
		side_in.value  = '0;
		side_in.status = csa_pkg::ST_OK;
		side_in.qneg   = qneg_s2;
		side_in.rneg   = rneg_s2;
		unique case (kind_s2)
			csa_pkg::KIND_ADD, csa_pkg::KIND_SUB: begin
				if (!sum_s2[W] && sum_s2[W-1]) begin
					side_in.status = csa_pkg::ST_OVER;
				end else if (sum_s2[W] && !sum_s2[W-1]) begin
					side_in.status = csa_pkg::ST_UNDER;
				end else begin
					side_in.value = sum_s2[W-1:0];
				end
			end
			csa_pkg::KIND_MUL: begin
				if (!prod_s2[2*W-1] && (prod_s2[2*W-2:W-1] != '0)) begin
					side_in.status = csa_pkg::ST_OVER;
				end else if (prod_s2[2*W-1] && (prod_s2[2*W-2:W-1] != '1)) begin
					side_in.status = csa_pkg::ST_UNDER;
				end else begin
					side_in.value = prod_s2[W-1:0];
				end
			end
			csa_pkg::KIND_DIV, csa_pkg::KIND_REM: begin
				if (bzero_s2) begin
					side_in.status = csa_pkg::ST_DIVZERO;
				end
			end
			default: begin
				side_in.value = '0;
			end
		endcase
	end

	csa_div #(
		.W (W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.dividend  (amag_s2),
		.divisor   (bmag_s2),
		.side_in   (side_in),
		.out_valid (dv_valid),
		.quotient  (dv_quo),
		.remainder (dv_rem),
		.side_out  (dv_side)
	);

	// sign fix-up and quotient overflow check for divide and remainder
	always_comb begin
		fin_value  = dv_side.value;
		fin_status = dv_side.status;
		if (dv_side.status == csa_pkg::ST_OK) begin
			if (dv_side.kind == csa_pkg::KIND_DIV) begin
				if (dv_side.qneg) begin
					fin_value = ~dv_quo + 1'b1;
				end else if (dv_quo[W-1]) begin
					fin_value  = '0;
					fin_status = csa_pkg::ST_OVER;
				end else begin
					fin_value = dv_quo;
				end
			end else if (dv_side.kind == csa_pkg::KIND_REM) begin
				fin_value = dv_side.rneg ? (~dv_rem + 1'b1) : dv_rem;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value  <= fin_value;
			status <= fin_status;
		end
	end

endmodule
